// ===== hdl/vfc_pkg.sv =====
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared types, widths and constant tables for the vehicle follow control law.
// ----------------------------------------------------------------------------
package vfc_pkg;

  localparam int ATAN_LEN = 24;
  localparam int ROT_W    = 34;
  localparam int VEC_W    = 56;
  localparam int ANG_W    = 34;

  localparam logic signed [ROT_W-1:0] ROT_GAIN     = 34'sd652032874;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1073741824;

  typedef enum logic [2:0] {
    REG_GAIN  = 3'd0,
    REG_SOFT  = 3'd1,
    REG_STIFF = 3'd2,
    REG_DAMP  = 3'd3,
    REG_AXLE  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] z;
  } rot_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic [15:0]        eh;
    logic [15:0]        rh;
    logic signed [15:0] es;
    logic signed [15:0] rs;
  } pay_t;

  typedef struct packed {
    logic signed [15:0] acc;
    logic signed [16:0] dh;
    logic               zero_num;
    logic               den_neg;
  } side_t;

  // arctan(2^-i) in 2^32 units per turn
  function automatic logic [29:0] atan_turn(input int unsigned i);
    case (i)
      0:  atan_turn = 30'd536870912;
      1:  atan_turn = 30'd316933406;
      2:  atan_turn = 30'd167458907;
      3:  atan_turn = 30'd85004756;
      4:  atan_turn = 30'd42667331;
      5:  atan_turn = 30'd21354465;
      6:  atan_turn = 30'd10680862;
      7:  atan_turn = 30'd5340245;
      8:  atan_turn = 30'd2670163;
      9:  atan_turn = 30'd1335087;
      10: atan_turn = 30'd667544;
      11: atan_turn = 30'd333772;
      12: atan_turn = 30'd166886;
      13: atan_turn = 30'd83443;
      14: atan_turn = 30'd41722;
      15: atan_turn = 30'd20861;
      16: atan_turn = 30'd10430;
      17: atan_turn = 30'd5215;
      18: atan_turn = 30'd2608;
      19: atan_turn = 30'd1304;
      20: atan_turn = 30'd652;
      21: atan_turn = 30'd326;
      22: atan_turn = 30'd163;
      23: atan_turn = 30'd81;
      default: atan_turn = 30'd0;
    endcase
  endfunction

  function automatic logic heading_flip(input logic [15:0] h);
    heading_flip = (h[15:14] == 2'd1) || (h[15:14] == 2'd2);
  endfunction

  // fold the heading by a half turn into the quarter-turn range
  function automatic rot_t rot_start(input logic [15:0] h);
    rot_t r;
    logic signed [ROT_W-1:0] z;
    z = $signed({2'b00, h, 16'h0000});
    if (heading_flip(h)) z = z - 34'sd2147483648;
    if (z >= 34'sd2147483648) z = z - 34'sd4294967296;
    r.x = ROT_GAIN;
    r.y = '0;
    r.z = z;
    rot_start = r;
  endfunction

endpackage

// ===== hdl/vfc_rot_cell.sv =====
// ----------------------------------------------------------------------------
// vfc_rot_cell
// One rotation-mode cordic micro-rotation, registered.
// ----------------------------------------------------------------------------
module vfc_rot_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           en,
  input  vfc_pkg::rot_t  din,
  output vfc_pkg::rot_t  dout
);

  logic signed [vfc_pkg::ROT_W-1:0] xs;
  logic signed [vfc_pkg::ROT_W-1:0] ys;
  logic signed [vfc_pkg::ROT_W-1:0] at;
  vfc_pkg::rot_t                    nxt;

  assign xs = $signed(din.x) >>> IDX;
  assign ys = $signed(din.y) >>> IDX;
  assign at = $signed({4'b0000, vfc_pkg::atan_turn(IDX)});

  always_comb begin
    if ($signed(din.z) >= 0) begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.z = din.z - at;
    end else begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.z = din.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout <= nxt;
  end

endmodule

// ===== hdl/vfc_norm_cell.sv =====
// ----------------------------------------------------------------------------
// vfc_norm_cell
// One step of the atan2 operand normalisation: shift both when both are small.
// ----------------------------------------------------------------------------
module vfc_norm_cell #(
  parameter int SHIFT = 1,
  parameter int LIMIT = 48
) (
  input  logic           clk,
  input  logic           en,
  input  vfc_pkg::vec_t  din,
  output vfc_pkg::vec_t  dout
);

  logic [vfc_pkg::VEC_W-1:0] ax;
  logic [vfc_pkg::VEC_W-1:0] ay;
  logic                      small_mag;
  vfc_pkg::vec_t             nxt;

  assign ax = din.x[vfc_pkg::VEC_W-1] ? vfc_pkg::VEC_W'(-din.x) : vfc_pkg::VEC_W'(din.x);
  assign ay = din.y[vfc_pkg::VEC_W-1] ? vfc_pkg::VEC_W'(-din.y) : vfc_pkg::VEC_W'(din.y);
  assign small_mag = (ax[vfc_pkg::VEC_W-1:LIMIT] == '0) && (ay[vfc_pkg::VEC_W-1:LIMIT] == '0);

  always_comb begin
    nxt = din;
    if (small_mag) begin
      nxt.x = $signed(din.x) <<< SHIFT;
      nxt.y = $signed(din.y) <<< SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout <= nxt;
  end

endmodule

// ===== hdl/vfc_vec_cell.sv =====
// ----------------------------------------------------------------------------
// vfc_vec_cell
// One vectoring-mode cordic micro-rotation, registered.
// ----------------------------------------------------------------------------
module vfc_vec_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           en,
  input  vfc_pkg::vec_t  din,
  output vfc_pkg::vec_t  dout
);

  logic signed [vfc_pkg::VEC_W-1:0] xs;
  logic signed [vfc_pkg::VEC_W-1:0] ys;
  logic signed [vfc_pkg::ANG_W-1:0] at;
  vfc_pkg::vec_t                    nxt;

  assign xs = $signed(din.x) >>> IDX;
  assign ys = $signed(din.y) >>> IDX;
  assign at = $signed({4'b0000, vfc_pkg::atan_turn(IDX)});

  always_comb begin
    if ($signed(din.y) > 0) begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.z = din.z + at;
    end else begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.z = din.z - at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout <= nxt;
  end

endmodule

// ===== hdl/vehicle_follow_control_law_top.sv =====
// ----------------------------------------------------------------------------
// vehicle_follow_control_law_top
// Throughput: one item per cycle unless stalled; cordic rows, one cell a cycle.
// An output register plus one skid entry; input ready drops only when skid full.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module vehicle_follow_control_law_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] ego_x,
  input  logic signed [31:0] ego_y,
  input  logic [15:0]        ego_heading,
  input  logic signed [15:0] ego_speed,
  input  logic signed [31:0] ref_x,
  input  logic signed [31:0] ref_y,
  input  logic [15:0]        ref_heading,
  input  logic signed [15:0] ref_speed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] acceleration,
  output logic signed [18:0] steering,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int STEPS = (CORDIC_STEPS > vfc_pkg::ATAN_LEN) ? vfc_pkg::ATAN_LEN : CORDIC_STEPS;
  localparam int NORM  = 7;
  localparam int NV    = NORM + 1 + STEPS;
  localparam int DEPTH = 2 * STEPS + 15;
  localparam int NSH [NORM] = '{32, 16, 8, 4, 2, 1, 1};
  localparam int NLIM[NORM] = '{16, 32, 40, 44, 46, 47, 48};

  // configuration
  logic [15:0] gain, softening, stiff, damp, axle;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= 16'd2560;
      softening <= 16'd256;
      stiff     <= 16'd256;
      damp      <= 16'd512;
      axle      <= 16'd717;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vfc_pkg::REG_GAIN:  gain      <= cfg_data;
        vfc_pkg::REG_SOFT:  softening <= cfg_data;
        vfc_pkg::REG_STIFF: stiff     <= cfg_data;
        vfc_pkg::REG_DAMP:  damp      <= cfg_data;
        vfc_pkg::REG_AXLE:  axle      <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic             en;
  logic             skid_valid;
  logic [DEPTH-1:0] vld;

  assign en       = !skid_valid;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // input register
  vfc_pkg::pay_t s0;

  always_ff @(posedge clk) begin
    if (en) begin
      s0.ex <= ego_x;
      s0.ey <= ego_y;
      s0.eh <= ego_heading;
      s0.es <= ego_speed;
      s0.rx <= ref_x;
      s0.ry <= ref_y;
      s0.rh <= ref_heading;
      s0.rs <= ref_speed;
    end
  end

  // heading rotation rows, payload travelling alongside
  vfc_pkg::rot_t rchain [0:STEPS];
  vfc_pkg::rot_t echain [0:STEPS];
  vfc_pkg::pay_t pc     [1:STEPS];

  assign rchain[0] = vfc_pkg::rot_start(s0.rh);
  assign echain[0] = vfc_pkg::rot_start(s0.eh);

  for (genvar k = 0; k < STEPS; k++) begin : g_rot
    vfc_rot_cell #(.IDX(k)) u_ref (
      .clk(clk), .en(en), .din(rchain[k]), .dout(rchain[k+1])
    );
    vfc_rot_cell #(.IDX(k)) u_ego (
      .clk(clk), .en(en), .din(echain[k]), .dout(echain[k+1])
    );
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) pc[1] <= s0;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) pc[k+1] <= pc[k];
      end
    end
  end

  // stage a: trig sign fix, front axle offset, differences
  vfc_pkg::pay_t      pa;
  logic               ref_flip, ego_flip;
  logic signed [33:0] rcos, rsin, ecos, esin, rc_w, rs_w;
  logic signed [50:0] fax_p, fay_p, fax_w, fay_w;
  logic signed [17:0] dh_raw, dh_wrap;

  assign pa       = pc[STEPS];
  assign ref_flip = vfc_pkg::heading_flip(pa.rh);
  assign ego_flip = vfc_pkg::heading_flip(pa.eh);
  assign rcos     = ref_flip ? -rchain[STEPS].x : rchain[STEPS].x;
  assign rsin     = ref_flip ? -rchain[STEPS].y : rchain[STEPS].y;
  assign ecos     = ego_flip ? -echain[STEPS].x : echain[STEPS].x;
  assign esin     = ego_flip ? -echain[STEPS].y : echain[STEPS].y;
  assign rc_w     = (rcos + 34'sd2) >>> 2;
  assign rs_w     = (rsin + 34'sd2) >>> 2;
  assign fax_p    = $signed({1'b0, axle}) * ecos;
  assign fay_p    = $signed({1'b0, axle}) * esin;
  assign fax_w    = (fax_p + 51'sd2097152) >>> 22;
  assign fay_w    = (fay_p + 51'sd2097152) >>> 22;
  assign dh_raw   = $signed({2'b00, pa.rh}) - $signed({2'b00, pa.eh});

  always_comb begin
    dh_wrap = dh_raw;
    if (dh_raw > 18'sd32768) dh_wrap = dh_raw - 18'sd65536;
    else if (dh_raw < -18'sd32768) dh_wrap = dh_raw + 18'sd65536;
    if (pa.es < 0) dh_wrap = -dh_wrap;
  end

  logic signed [30:0] a_rc, a_rs;
  logic signed [25:0] a_fax, a_fay;
  logic signed [32:0] a_ddx, a_ddy;
  logic signed [16:0] a_dh, a_dv;
  logic signed [15:0] a_es;

  always_ff @(posedge clk) begin
    if (en) begin
      a_rc  <= rc_w[30:0];
      a_rs  <= rs_w[30:0];
      a_fax <= (pa.es < 0) ? 26'sd0 : fax_w[25:0];
      a_fay <= (pa.es < 0) ? 26'sd0 : fay_w[25:0];
      a_ddx <= 33'(pa.ex) - 33'(pa.rx);
      a_ddy <= 33'(pa.ey) - 33'(pa.ry);
      a_dh  <= dh_wrap[16:0];
      a_dv  <= 17'(pa.es) - 17'(pa.rs);
      a_es  <= pa.es;
    end
  end

  // stage b: projection products
  logic signed [33:0] b_ax, b_ay;
  logic signed [64:0] b_p1, b_p2, b_p3, b_p4;
  logic signed [16:0] b_dh, b_dv;
  logic signed [15:0] b_es;

  assign b_ax = 34'(a_ddx) + 34'(a_fax);
  assign b_ay = 34'(a_ddy) + 34'(a_fay);

  always_ff @(posedge clk) begin
    if (en) begin
      b_p1 <= b_ax * a_rs;
      b_p2 <= b_ay * a_rc;
      b_p3 <= a_ddx * a_rc;
      b_p4 <= a_ddy * a_rs;
      b_dh <= a_dh;
      b_dv <= a_dv;
      b_es <= a_es;
    end
  end

  // stage c: cross-track and along-track errors
  logic signed [65:0] dy_w, dx_w;
  logic signed [37:0] c_dy, c_dx;
  logic signed [16:0] c_dh, c_dv;
  logic signed [15:0] c_es;

  assign dy_w = (66'(b_p1) - 66'(b_p2) + 66'sd134217728) >>> 28;
  assign dx_w = (66'(b_p3) + 66'(b_p4) + 66'sd134217728) >>> 28;

  always_ff @(posedge clk) begin
    if (en) begin
      c_dy <= dy_w[37:0];
      c_dx <= dx_w[37:0];
      c_dh <= b_dh;
      c_dv <= b_dv;
      c_es <= b_es;
    end
  end

  // stage d: gains
  logic signed [54:0] d_num, d_kdx;
  logic signed [33:0] d_ddv;
  logic signed [16:0] d_dh;
  logic signed [15:0] d_es;

  always_ff @(posedge clk) begin
    if (en) begin
      d_num <= $signed({1'b0, gain}) * c_dy;
      d_kdx <= $signed({1'b0, stiff}) * c_dx;
      d_ddv <= $signed({1'b0, damp}) * c_dv;
      d_dh  <= c_dh;
      d_es  <= c_es;
    end
  end

  // stage e: acceleration, atan2 operands
  logic signed [57:0] acc_w;
  logic signed [17:0] den;
  logic signed [15:0] acc_sat;
  vfc_pkg::vec_t      e_vec;
  vfc_pkg::side_t     e_side;

  assign acc_w = (-58'(d_kdx) - (58'(d_ddv) <<< 8) + 58'sd32768) >>> 16;
  assign den   = $signed({2'b00, softening}) + 18'(d_es);

  always_comb begin
    if (acc_w > 58'sd32767) acc_sat = 16'sh7fff;
    else if (acc_w < -58'sd32768) acc_sat = -16'sh8000;
    else acc_sat = acc_w[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_vec.x           <= vfc_pkg::VEC_W'(den) <<< 16;
      e_vec.y           <= vfc_pkg::VEC_W'(d_num);
      e_vec.z           <= '0;
      e_side.acc        <= acc_sat;
      e_side.dh         <= d_dh;
      e_side.zero_num   <= (d_num == '0);
      e_side.den_neg    <= den[17];
    end
  end

  // normalisation row, quarter-turn pre-rotation, vectoring row
  vfc_pkg::vec_t  nchain [0:NORM];
  vfc_pkg::vec_t  vchain [0:STEPS];
  vfc_pkg::vec_t  p_nxt, p_vec;
  vfc_pkg::side_t sd [1:NV];

  assign nchain[0] = e_vec;

  for (genvar k = 0; k < NORM; k++) begin : g_norm
    vfc_norm_cell #(.SHIFT(NSH[k]), .LIMIT(NLIM[k])) u_norm (
      .clk(clk), .en(en), .din(nchain[k]), .dout(nchain[k+1])
    );
  end

  always_comb begin
    p_nxt = nchain[NORM];
    if (nchain[NORM].x < 0) begin
      if (nchain[NORM].y >= 0) begin
        p_nxt.x = nchain[NORM].y;
        p_nxt.y = -nchain[NORM].x;
        p_nxt.z = vfc_pkg::QUARTER_TURN;
      end else begin
        p_nxt.x = -nchain[NORM].y;
        p_nxt.y = nchain[NORM].x;
        p_nxt.z = -vfc_pkg::QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) p_vec <= p_nxt;
  end

  assign vchain[0] = p_vec;

  for (genvar k = 0; k < STEPS; k++) begin : g_vec
    vfc_vec_cell #(.IDX(k)) u_vec (
      .clk(clk), .en(en), .din(vchain[k]), .dout(vchain[k+1])
    );
  end

  for (genvar k = 1; k <= NV; k++) begin : g_side
    if (k == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (en) sd[1] <= e_side;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) sd[k] <= sd[k-1];
      end
    end
  end

  // stage f: steering angle
  logic signed [33:0] ang_w;
  logic signed [17:0] ang_sel;
  logic signed [15:0] f_acc;
  logic signed [18:0] f_steer;

  assign ang_w = (vchain[STEPS].z + 34'sd32768) >>> 16;

  always_comb begin
    if (sd[NV].zero_num) ang_sel = sd[NV].den_neg ? 18'sd32768 : 18'sd0;
    else ang_sel = ang_w[17:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_acc   <= sd[NV].acc;
      f_steer <= 19'(sd[NV].dh) + 19'(ang_sel);
    end
  end

  // output register with one skid entry
  logic               take;
  logic signed [15:0] skid_acc;
  logic signed [18:0] skid_steer;

  assign take = vld[DEPTH-1] && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= take;
      end
    end else if (take) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      acceleration <= skid_valid ? skid_acc : f_acc;
      steering     <= skid_valid ? skid_steer : f_steer;
    end else if (take) begin
      skid_acc   <= f_acc;
      skid_steer <= f_steer;
    end
  end

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output item");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid filled while output was free");

  a_last_held: assert property (@(posedge clk) disable iff (rst)
    (vld[DEPTH-1] && skid_valid) |=> vld[DEPTH-1])
    else $error("last stage item dropped during stall");

endmodule

// ===== bench/vehicle_follow_control_law_top_test.sv =====
// ----------------------------------------------------------------------------
// vehicle_follow_control_law_top_test
// Self-checking bench for the follow controller. Items go in through the
// valid/ready input channel. A bit-exact predictor of the spring and Stanley
// laws, CORDICs included, queues the expected acceleration and steering. Each
// result is checked against the oldest entry of that queue. The registers are
// swept through defaults, extremes and random settings, with random gaps on
// both sides and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module vehicle_follow_control_law_top_test;

  localparam int    STEPS      = 16;
  localparam int    LATENCY    = 2*STEPS+15;
  localparam int    IDLE_LIMIT = 4000;
  localparam longint HALF32    = 64'sd2147483648;

  localparam longint ATAN_STEP [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    logic signed [31:0] ex, ey, rx, ry;
    logic [15:0]        eh, rh;
    logic signed [15:0] es, rs;
  } pose_item_t;

  typedef struct {
    logic signed [15:0] accel;
    logic signed [18:0] steer;
  } command_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] ego_x = '0, ego_y = '0, ref_x = '0, ref_y = '0;
  logic [15:0] ego_heading = '0, ref_heading = '0;
  logic signed [15:0] ego_speed = '0, ref_speed = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] acceleration;
  logic signed [18:0] steering;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // register copy used by the predictor
  logic [15:0] gain_q, soft_q, stiff_q, damp_q, axle_q;

  command_t command_q[$];
  int fails = 0;
  int idle_cycles = 0;
  int hold_request = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  vehicle_follow_control_law_top #(.CORDIC_STEPS(STEPS)) i_dut (.*);

  always #5 clk = ~clk;

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s-1))) >>> s;
  endfunction

  function automatic void heading_trig(input logic [15:0] h, output longint c,
                                       output longint s);
    longint x, y, z, xs, ys;
    logic flip;
    flip = (h[15:14] == 2'd1) || (h[15:14] == 2'd2);
    z = longint'(h) * 65536;
    x = 652032874;
    y = 0;
    if (flip) z = z - HALF32;
    if (z >= HALF32) z = z - 2*HALF32;
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ATAN_STEP[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ATAN_STEP[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint vector_angle(longint num, longint den);
    longint x, y, z, t, ax, ay, xs, ys;
    if (num == 0) return (den < 0) ? 32768 : 0;
    x = den;
    y = num;
    z = 0;
    for (int i = 0; i < 64; i++) begin
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      if (((ax > ay) ? ax : ay) >= (64'sd1 <<< 48)) break;
      x = x * 2;
      y = y * 2;
    end
    // left half plane: quarter turn first
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 64'sd1073741824;
      end else begin
        x = -y; y = t; z = -64'sd1073741824;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_STEP[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_STEP[i];
      end
    end
    return round_shift(z, 16);
  endfunction

  function automatic command_t follow_command(pose_item_t p);
    command_t r;
    longint ex, ey, rx, ry, es, rs, ec, esn, rc, rsn, fax, fay, dy, dx, dh, acc, st;
    ex = longint'(p.ex); ey = longint'(p.ey);
    rx = longint'(p.rx); ry = longint'(p.ry);
    es = longint'(p.es); rs = longint'(p.rs);
    fax = 0;
    fay = 0;
    heading_trig(p.rh, rc, rsn);
    rc = round_shift(rc, 2);
    rsn = round_shift(rsn, 2);
    if (es >= 0) begin
      heading_trig(p.eh, ec, esn);
      fax = round_shift(longint'(axle_q) * ec, 22);
      fay = round_shift(longint'(axle_q) * esn, 22);
    end
    dy = round_shift((ex + fax - rx) * rsn - (ey + fay - ry) * rc, 28);
    dx = round_shift((ex - rx) * rc + (ey - ry) * rsn, 28);
    acc = round_shift(-longint'(stiff_q) * dx - longint'(damp_q) * (es - rs) * 256, 16);
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    dh = longint'(p.rh) - longint'(p.eh);
    if (dh > 32768) dh = dh - 65536;
    else if (dh < -32768) dh = dh + 65536;
    if (es < 0) dh = -dh;
    st = dh + vector_angle(longint'(gain_q) * dy, (longint'(soft_q) + es) * 65536);
    r.accel = acc[15:0];
    r.steer = st[18:0];
    return r;
  endfunction

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic wait_drained();
    while (command_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(vfc_pkg::cfg_reg_t idx, logic [15:0] val);
    wait_drained();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      vfc_pkg::REG_GAIN:  gain_q = val;
      vfc_pkg::REG_SOFT:  soft_q = val;
      vfc_pkg::REG_STIFF: stiff_q = val;
      vfc_pkg::REG_DAMP:  damp_q = val;
      vfc_pkg::REG_AXLE:  axle_q = val;
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] g, logic [15:0] s, logic [15:0] k,
                           logic [15:0] d, logic [15:0] a);
    write_reg(vfc_pkg::REG_GAIN, g);
    write_reg(vfc_pkg::REG_SOFT, s);
    write_reg(vfc_pkg::REG_STIFF, k);
    write_reg(vfc_pkg::REG_DAMP, d);
    write_reg(vfc_pkg::REG_AXLE, a);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(pose_item_t p);
    int gap;
    gap = gaps_on ? random_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    ego_x = p.ex; ego_y = p.ey; ego_heading = p.eh; ego_speed = p.es;
    ref_x = p.rx; ref_y = p.ry; ref_heading = p.rh; ref_speed = p.rs;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    command_q.push_back(follow_command(p));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_pose(logic signed [31:0] ex, logic signed [31:0] ey,
                           logic [15:0] eh, logic signed [15:0] es,
                           logic signed [31:0] rx, logic signed [31:0] ry,
                           logic [15:0] rh, logic signed [15:0] rs);
    pose_item_t p;
    p.ex = ex; p.ey = ey; p.eh = eh; p.es = es;
    p.rx = rx; p.ry = ry; p.rh = rh; p.rs = rs;
    send_item(p);
  endtask

  function automatic pose_item_t random_pose();
    pose_item_t p;
    int r;
    r = $urandom_range(0, 99);
    p.eh = 16'($urandom());
    p.rh = 16'($urandom());
    if (r < 15) begin
      // noise over the full field ranges
      p.ex = $urandom(); p.ey = $urandom(); p.rx = $urandom(); p.ry = $urandom();
      p.es = 16'($urandom()); p.rs = 16'($urandom());
    end else begin
      // a plausible following scene: reference within tens of metres
      p.ex = $urandom();
      p.ey = $urandom();
      p.rx = p.ex + $signed($urandom_range(0, 32'h0060_0000)) - 32'sh0030_0000;
      p.ry = p.ey + $signed($urandom_range(0, 32'h0060_0000)) - 32'sh0030_0000;
      p.es = $signed(16'($urandom_range(0, 16'h2000))) - 16'sh0800;
      p.rs = $signed(16'($urandom_range(0, 16'h2000))) - 16'sh0800;
      if (r < 25) p.rh = p.eh + 16'($urandom_range(0, 600)) - 16'd300;
      if (r > 95) begin
        p.rx = p.ex; p.ry = p.ey;
      end
    end
    return p;
  endfunction

  task automatic test_directed();
    send_pose(0, 0, 16'h0000, 0, 0, 0, 16'h0000, 0);
    send_pose(32'sh7fffffff, 32'sh7fffffff, 16'hffff, 16'sh7fff,
              32'sh80000000, 32'sh80000000, 16'h0000, 16'sh8000);
    send_pose(32'sh80000000, 32'sh80000000, 16'h0000, 16'sh8000,
              32'sh7fffffff, 32'sh7fffffff, 16'hffff, 16'sh7fff);
    send_pose(32'sh00010000, 0, 16'h4000, 16'sh0100, 0, 0, 16'h4000, 0);
    send_pose(0, 32'sh00020000, 16'h8000, 16'sh0200, 0, 0, 16'hc000, 16'sh0100);
    send_pose(-32'sh00050000, 32'sh00030000, 16'hc000, 16'sh0300, 0, 0, 16'h3fff, 0);
    // heading difference exactly plus and minus a half turn
    send_pose(0, 32'sh00010000, 16'h0000, 16'sh0400, 0, 0, 16'h8000, 0);
    send_pose(0, 32'sh00010000, 16'h8000, 16'sh0400, 0, 0, 16'h0000, 0);
    send_pose(32'sh00008000, 0, 16'h0001, 16'sh0100, 0, 0, 16'h8001, 0);
    // reversing: no front axle point and heading error flipped
    send_pose(0, 32'sh00010000, 16'h1000, -16'sh0100, 0, 0, 16'h2000, 0);
    // zero numerator with negative denominator
    send_pose(32'sh00123456, 32'sh00654321, 16'h2345, -16'sh0200,
              32'sh00123456, 32'sh00654321, 16'h2345, 16'sh0100);
    // zero numerator with positive denominator
    send_pose(32'sh00010000, 32'sh00020000, 16'h1111, -16'sh0080,
              32'sh00010000, 32'sh00020000, 16'h1111, 0);
    // negative denominator, cross-track error both ways
    send_pose(0, 32'sh00030000, 16'h0000, -16'sh0400, 0, 0, 16'h0000, 0);
    send_pose(0, -32'sh00030000, 16'h0000, -16'sh0400, 0, 0, 16'h0000, 0);
    send_pose(0, 0, 16'h0000, 16'sh8000, 0, 32'sh00100000, 16'h4000, 16'sh7fff);
    send_pose(32'sh7fff0000, 0, 16'h7fff, 16'sh7fff, -32'sh7fff0000, 0, 16'h8000, 16'sh8000);
    send_pose(32'sh00400000, 32'sh00400000, 16'h2000, 16'sh1000, 0, 0, 16'h2000, 16'sh0800);
    send_pose(-32'sh00400000, 32'sh00400000, 16'he000, 16'sh0001, 0, 0, 16'h6000, -16'sh0001);
  endtask

  task automatic test_random(int n);
    repeat (n) begin
      send_item(random_pose());
      if ($urandom_range(0, 99) == 0) begin
        // sender waits for the pipeline to empty
        in_valid = 1'b0;
        wait_drained();
      end
    end
  endtask

  task automatic test_unknown_index();
    wait_drained();
    for (int i = 5; i < 8; i++) begin
      cfg_we = 1'b1;
      cfg_index = 3'(i);
      cfg_data = 16'($urandom());
      @(negedge clk);
    end
    cfg_we = 1'b0;
    test_directed();
  endtask

  task automatic test_backpressure();
    in_valid = 1'b0;
    wait_drained();
    gaps_on = 1'b0;
    hold_request = 300;
    test_random(90);
    gaps_on = 1'b1;
  endtask

  // receiver: random stalls, one requested long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else if (!stalls_on) begin
        out_ready = 1'b1;
      end else begin
        out_ready = ($urandom_range(0, 99) < 70);
        if ($urandom_range(0, 99) < 2) hold_left = $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    command_t e;
    if (!rst && out_valid && out_ready) begin
      if (command_q.size() == 0) begin
        $error("result with no item outstanding");
        fails++;
      end else begin
        e = command_q.pop_front();
        if (acceleration !== e.accel) begin
          $error("acceleration: expected %0d, got %0d", e.accel, acceleration);
          fails++;
        end
        if (steering !== e.steer) begin
          $error("steering: expected %0d, got %0d", e.steer, steering);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("vehicle_follow_control_law_top test failed");
        $finish;
      end
    end
  end

  initial begin
    gain_q = 16'd2560; soft_q = 16'd256; stiff_q = 16'd256;
    damp_q = 16'd512; axle_q = 16'd717;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_unknown_index();
    write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    test_directed();
    write_all(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    test_directed();
    test_random(40);
    write_all(16'd2560, 16'd256, 16'd256, 16'd512, 16'd717);
    test_backpressure();
    stalls_on = 1'b0;
    test_random(60);
    stalls_on = 1'b1;
    write_all(16'($urandom()), 16'($urandom()), 16'($urandom()),
              16'($urandom()), 16'($urandom()));
    test_random(90);
    write_all(16'($urandom_range(0, 4096)), 16'($urandom_range(0, 1024)),
              16'($urandom_range(0, 1024)), 16'($urandom_range(0, 2048)),
              16'($urandom_range(0, 2048)));
    test_random(100);

    in_valid = 1'b0;
    wait_drained();
    repeat (2*LATENCY) @(negedge clk);
    if (fails == 0) begin
      $display("vehicle_follow_control_law_top test passed");
    end else begin
      $display("vehicle_follow_control_law_top test failed");
    end
    $finish;
  end

endmodule
